>>> rtl/wsst_pkg.sv
// ----------------------------------------------------------------------------
// wsst_pkg
// Shared types and constants of the wingbeat synced strobe trigger: the
// configuration record, register indexes, reset values, the controller
// state encoding and the command/status records between control and datapath.
// ----------------------------------------------------------------------------
package wsst_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_TRIGGER_PERCENT  = 3'd0;
  localparam logic [2:0] REG_ACCEPT_LIMIT     = 3'd1;
  localparam logic [2:0] REG_FLYING_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_FALLBACK_PERIOD  = 3'd3;
  localparam logic [2:0] REG_LED_PULSE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_PULSES_PER_FRAME = 3'd5;
  localparam logic [2:0] REG_LEFT_ENABLE      = 3'd6;
  localparam logic [2:0] REG_RIGHT_ENABLE     = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int TIME_W      = 32;
  localparam int PERIOD_W    = 24;
  localparam int PERCENT_W   = 7;
  localparam int COUNT_W     = 8;
  // avg (24 bit) times percent (7 bit)
  localparam int PROD_W      = PERIOD_W + PERCENT_W;
  // since_beat times 100 needs 7 extra bits
  localparam int SCALED_W    = TIME_W + PERCENT_W;

  localparam logic [PERCENT_W-1:0] PERCENT_MAX = 7'd100;

  // reset values of the registers
  localparam logic [PERCENT_W-1:0] RST_TRIGGER_PERCENT  = 7'd50;
  localparam logic [PERIOD_W-1:0]  RST_ACCEPT_LIMIT     = 24'd10000;
  localparam logic [PERIOD_W-1:0]  RST_FLYING_TIMEOUT   = 24'd100000;
  localparam logic [PERIOD_W-1:0]  RST_FALLBACK_PERIOD  = 24'd5000;
  localparam logic [PERIOD_W-1:0]  RST_LED_PULSE_WIDTH  = 24'd500;
  localparam logic [COUNT_W-1:0]   RST_PULSES_PER_FRAME = 8'd4;

  typedef struct packed {
    logic [PERCENT_W-1:0] trigger_percent;
    logic [PERIOD_W-1:0]  average_accept_limit;
    logic [PERIOD_W-1:0]  flying_timeout;
    logic [PERIOD_W-1:0]  fallback_period;
    logic [PERIOD_W-1:0]  led_pulse_width;
    logic [COUNT_W-1:0]   pulses_per_frame;
    logic                 left_camera_enable;
    logic                 right_camera_enable;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RING,
    ST_DIV_INIT,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic ring;      // beat, timeout, fallback and average ring update
    logic div_init;  // load the divider with the sum, clear the remainder
    logic div_step;  // one quotient bit
    logic mul;       // average times percent
    logic fin;       // pulse logic and result register load
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new item this cycle
  } sts_t;

endpackage

>>> rtl/wsst_ram.sv
// ----------------------------------------------------------------------------
// wsst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsst_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/wsst_cfg.sv
// ----------------------------------------------------------------------------
// wsst_cfg
// Configuration register file; the trigger percent saturates at 100.
// ----------------------------------------------------------------------------
module wsst_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsst_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wsst_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output wsst_pkg::cfg_t                    cfg
);

  wsst_pkg::cfg_t cfg_r;
  wsst_pkg::cfg_t cfg_nxt;
  logic [wsst_pkg::PERCENT_W-1:0] pct_in;

  assign cfg_ready = 1'b1;
  assign pct_in    = cfg_wdata[wsst_pkg::PERCENT_W-1:0];

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        wsst_pkg::REG_TRIGGER_PERCENT: begin
          cfg_nxt.trigger_percent = (pct_in > wsst_pkg::PERCENT_MAX) ?
                                    wsst_pkg::PERCENT_MAX : pct_in;
        end
        wsst_pkg::REG_ACCEPT_LIMIT:     cfg_nxt.average_accept_limit = cfg_wdata;
        wsst_pkg::REG_FLYING_TIMEOUT:   cfg_nxt.flying_timeout = cfg_wdata;
        wsst_pkg::REG_FALLBACK_PERIOD:  cfg_nxt.fallback_period = cfg_wdata;
        wsst_pkg::REG_LED_PULSE_WIDTH:  cfg_nxt.led_pulse_width = cfg_wdata;
        wsst_pkg::REG_PULSES_PER_FRAME: begin
          cfg_nxt.pulses_per_frame = cfg_wdata[wsst_pkg::COUNT_W-1:0];
        end
        wsst_pkg::REG_LEFT_ENABLE:      cfg_nxt.left_camera_enable = cfg_wdata[0];
        wsst_pkg::REG_RIGHT_ENABLE:     cfg_nxt.right_camera_enable = cfg_wdata[0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_percent      <= wsst_pkg::RST_TRIGGER_PERCENT;
      cfg_r.average_accept_limit <= wsst_pkg::RST_ACCEPT_LIMIT;
      cfg_r.flying_timeout       <= wsst_pkg::RST_FLYING_TIMEOUT;
      cfg_r.fallback_period      <= wsst_pkg::RST_FALLBACK_PERIOD;
      cfg_r.led_pulse_width      <= wsst_pkg::RST_LED_PULSE_WIDTH;
      cfg_r.pulses_per_frame     <= wsst_pkg::RST_PULSES_PER_FRAME;
      cfg_r.left_camera_enable   <= 1'b1;
      cfg_r.right_camera_enable  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/wsst_ctrl.sv
// ----------------------------------------------------------------------------
// wsst_ctrl
// Controller: sequences capture, ring update, bit-serial division,
// threshold product and result load for one item at a time.
// ----------------------------------------------------------------------------
module wsst_ctrl #(
  parameter int DIV_STEPS = 28
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  wsst_pkg::sts_t sts,
  output wsst_pkg::cmd_t cmd
);

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  wsst_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wsst_pkg::ST_IDLE:     if (in_valid) state_nxt = wsst_pkg::ST_RING;
      wsst_pkg::ST_RING:     state_nxt = wsst_pkg::ST_DIV_INIT;
      wsst_pkg::ST_DIV_INIT: state_nxt = wsst_pkg::ST_DIV;
      wsst_pkg::ST_DIV:      if (cnt_r == '0) state_nxt = wsst_pkg::ST_MUL;
      wsst_pkg::ST_MUL:      state_nxt = wsst_pkg::ST_FIN;
      wsst_pkg::ST_FIN:      if (sts.out_free) state_nxt = wsst_pkg::ST_IDLE;
      default:               state_nxt = wsst_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      wsst_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      wsst_pkg::ST_RING:     cmd.ring = 1'b1;
      wsst_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      wsst_pkg::ST_DIV:      cmd.div_step = 1'b1;
      wsst_pkg::ST_MUL:      cmd.mul = 1'b1;
      wsst_pkg::ST_FIN:      cmd.fin = sts.out_free;
      default:               cmd = '0;
    endcase
  end

  // divide step counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == wsst_pkg::ST_DIV_INIT) begin
      cnt_nxt = CNT_W'(DIV_STEPS - 1);
    end else if (state_r == wsst_pkg::ST_DIV && cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsst_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/wsst_dp.sv
// ----------------------------------------------------------------------------
// wsst_dp
// Datapath: beat/flying state, period ring with running sum, restoring
// divider for the average, threshold compare, pulse and camera state and
// the result register.
// ----------------------------------------------------------------------------
module wsst_dp #(
  parameter int AVG_WINDOW = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wsst_pkg::cmd_t                    cmd,
  output wsst_pkg::sts_t                    sts,
  input  wsst_pkg::cfg_t                    cfg,
  input  logic [wsst_pkg::TIME_W-1:0]       in_now_us,
  input  logic                              in_wingbeat_seen,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_led_level,
  output logic                              out_left_trigger_level,
  output logic                              out_right_trigger_level,
  output logic                              out_left_trigger_driven,
  output logic                              out_right_trigger_driven,
  output logic                              out_flying
);

  localparam int POS_W  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int FILL_W = $clog2(AVG_WINDOW + 1);
  localparam int SUM_W  = wsst_pkg::PERIOD_W + $clog2(AVG_WINDOW);
  localparam int TW     = wsst_pkg::TIME_W;
  localparam int PW     = wsst_pkg::PERIOD_W;

  // captured item
  logic [TW-1:0] now_r, now_nxt;
  logic          beat_r, beat_nxt;

  // block state
  logic [TW-1:0]                   last_beat_r, last_beat_nxt;
  logic [TW-1:0]                   last_pulse_r, last_pulse_nxt;
  logic                            pulse_done_r, pulse_done_nxt;
  logic                            flying_r, flying_nxt;
  logic [wsst_pkg::COUNT_W-1:0]    fcount_r, fcount_nxt;
  logic [POS_W-1:0]                pos_r, pos_nxt;
  logic [FILL_W-1:0]               fill_r, fill_nxt;
  logic [SUM_W-1:0]                sum_r, sum_nxt;
  logic                            led_r, led_nxt;
  logic                            cam_r, cam_nxt;

  // divider and product
  logic [SUM_W-1:0]                quo_r, quo_nxt;
  logic [FILL_W-1:0]               rem_r, rem_nxt;
  logic [wsst_pkg::PROD_W-1:0]     prod_r, prod_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [5:0] res_r, res_nxt;

  // helpers
  logic [TW-1:0]                   gap;
  logic                            add_period;
  logic                            ring_full;
  logic [PW-1:0]                   ram_rdata;
  logic                            ram_we;
  logic [FILL_W:0]                 rem_shift;
  logic [FILL_W:0]                 rem_diff;
  logic                            rem_ge;
  logic [PW-1:0]                   avg;
  logic [TW-1:0]                   since_beat;
  logic [TW-1:0]                   since_pulse;
  logic [wsst_pkg::SCALED_W-1:0]   since_ext;
  logic [wsst_pkg::SCALED_W-1:0]   since_x100;
  logic                            fire;

  assign gap        = now_r - last_beat_r;
  assign add_period = beat_r && (gap < {{(TW - PW){1'b0}}, cfg.average_accept_limit});
  assign ring_full  = (fill_r == FILL_W'(AVG_WINDOW));
  assign ram_we     = cmd.ring && add_period;

  // period ring, read port sits on the oldest entry
  wsst_ram #(
    .WIDTH (PW),
    .DEPTH (AVG_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (gap[PW-1:0]),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // restoring divider bit
  assign rem_shift = {rem_r, quo_r[SUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, fill_r});
  assign rem_diff  = rem_shift - {1'b0, fill_r};

  // empty ring averages to zero; the quotient never exceeds a period
  assign avg = (fill_r == '0) ? '0 : quo_r[PW-1:0];

  // since_beat > floor(prod / 100)  <=>  prod < 100 * since_beat
  assign since_beat  = now_r - last_beat_r;
  assign since_pulse = now_r - last_pulse_r;
  assign since_ext   = {{wsst_pkg::PERCENT_W{1'b0}}, since_beat};
  assign since_x100  = (since_ext << 6) + (since_ext << 5) + (since_ext << 2);
  assign fire        = ({{(wsst_pkg::SCALED_W - wsst_pkg::PROD_W){1'b0}}, prod_r}
                        < since_x100);

  assign sts.out_free = !out_valid_r || !out_stall;

  // next values of the datapath
  always_comb begin
    now_nxt        = now_r;
    beat_nxt       = beat_r;
    last_beat_nxt  = last_beat_r;
    last_pulse_nxt = last_pulse_r;
    pulse_done_nxt = pulse_done_r;
    flying_nxt     = flying_r;
    fcount_nxt     = fcount_r;
    pos_nxt        = pos_r;
    fill_nxt       = fill_r;
    sum_nxt        = sum_r;
    led_nxt        = led_r;
    cam_nxt        = cam_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    prod_nxt       = prod_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;

    // capture
    if (cmd.load) begin
      now_nxt  = in_now_us;
      beat_nxt = in_wingbeat_seen;
    end

    // beat, average ring, timeout and fallback
    if (cmd.ring) begin
      if (beat_r) begin
        last_beat_nxt  = now_r;
        pulse_done_nxt = 1'b0;
        if (!flying_r) begin
          led_nxt = 1'b0;
          cam_nxt = 1'b0;
        end
        flying_nxt = 1'b1;
      end
      if (add_period) begin
        if (ring_full) begin
          sum_nxt = sum_r - SUM_W'(ram_rdata) + SUM_W'(gap[PW-1:0]);
        end else begin
          sum_nxt  = sum_r + SUM_W'(gap[PW-1:0]);
          fill_nxt = fill_r + 1'b1;
        end
        pos_nxt = (pos_r == POS_W'(AVG_WINDOW - 1)) ? '0 : pos_r + 1'b1;
      end
      if (gap > {{(TW - PW){1'b0}}, cfg.flying_timeout}) begin
        flying_nxt = 1'b0;
        fcount_nxt = '0;
      end
      if (!flying_nxt && (gap >= {{(TW - PW){1'b0}}, cfg.fallback_period})) begin
        last_beat_nxt  = now_r;
        pulse_done_nxt = 1'b0;
      end
    end

    // divider
    if (cmd.div_init) begin
      quo_nxt = sum_r;
      rem_nxt = '0;
    end
    if (cmd.div_step) begin
      quo_nxt = {quo_r[SUM_W-2:0], rem_ge};
      rem_nxt = rem_ge ? rem_diff[FILL_W-1:0] : rem_shift[FILL_W-1:0];
    end

    // threshold product
    if (cmd.mul) begin
      prod_nxt = {{wsst_pkg::PERCENT_W{1'b0}}, avg} *
                 {{PW{1'b0}}, cfg.trigger_percent};
    end

    // result register drains when taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // pulse logic and result load
    if (cmd.fin) begin
      if (!pulse_done_r) begin
        if (fire) begin
          led_nxt = 1'b1;
          if (fcount_r == '0) begin
            cam_nxt = 1'b1;
          end
          pulse_done_nxt = 1'b1;
          fcount_nxt     = fcount_r + 1'b1;
          last_pulse_nxt = now_r;
        end
      end else if (since_pulse > {{(TW - PW){1'b0}}, cfg.led_pulse_width}) begin
        led_nxt = 1'b0;
        if (fcount_r >= cfg.pulses_per_frame) begin
          cam_nxt    = 1'b0;
          fcount_nxt = '0;
        end
      end
      res_nxt = {led_nxt,
                 cfg.left_camera_enable && cam_nxt,
                 cfg.right_camera_enable && cam_nxt,
                 cfg.left_camera_enable,
                 cfg.right_camera_enable,
                 flying_r};
      out_valid_nxt = 1'b1;
    end
  end

  // control and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_beat_r  <= '0;
      last_pulse_r <= '0;
      pulse_done_r <= 1'b0;
      flying_r     <= 1'b0;
      fcount_r     <= '0;
      pos_r        <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      led_r        <= 1'b0;
      cam_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      last_beat_r  <= last_beat_nxt;
      last_pulse_r <= last_pulse_nxt;
      pulse_done_r <= pulse_done_nxt;
      flying_r     <= flying_nxt;
      fcount_r     <= fcount_nxt;
      pos_r        <= pos_nxt;
      fill_r       <= fill_nxt;
      sum_r        <= sum_nxt;
      led_r        <= led_nxt;
      cam_r        <= cam_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    now_r  <= now_nxt;
    beat_r <= beat_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_led_level            = res_r[5];
  assign out_left_trigger_level   = res_r[4];
  assign out_right_trigger_level  = res_r[3];
  assign out_left_trigger_driven  = res_r[2];
  assign out_right_trigger_driven = res_r[1];
  assign out_flying               = res_r[0];

endmodule

>>> rtl/wingbeat_synced_strobe_trigger.sv
// ----------------------------------------------------------------------------
// wingbeat_synced_strobe_trigger
// Strobe LED and camera trigger timed to a moving average of wingbeat periods.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel: one item per polling sample (in_now_us, in_wingbeat_seen),
//    taken when in_valid is high and in_stall low
//  - result channel: one item per input item (LED level, camera trigger levels
//    and drive enables, flying flag), taken when out_valid high, out_stall low
//  - cfg channel: register index and data, always ready; write only while idle
//  - each item passes through capture, ring update, divider load, the bit-serial
//    average divide (SUM_W = 24 + clog2(AVG_WINDOW) bits), threshold product and
//    result load; in_stall stays high from the ring update until the result load
//  - the next item is taken while a result still waits in the output
//    register; a stalled result only holds the block at the result load
//  - reset (rst_n low, synchronous) clears timing state, the average and the
//    output register and loads register defaults; the period ring itself is
//    not cleared, the fill count guards it
// ----------------------------------------------------------------------------
module wingbeat_synced_strobe_trigger #(
  parameter int AVG_WINDOW = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wsst_pkg::TIME_W-1:0]       in_now_us,
  input  logic                              in_wingbeat_seen,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_led_level,
  output logic                              out_left_trigger_level,
  output logic                              out_right_trigger_level,
  output logic                              out_left_trigger_driven,
  output logic                              out_right_trigger_driven,
  output logic                              out_flying,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsst_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wsst_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SUM_W = wsst_pkg::PERIOD_W + $clog2(AVG_WINDOW);

  wsst_pkg::cfg_t cfg;
  wsst_pkg::cmd_t cmd;
  wsst_pkg::sts_t sts;

  // configuration registers
  wsst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer
  wsst_ctrl #(
    .DIV_STEPS (SUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  wsst_dp #(
    .AVG_WINDOW (AVG_WINDOW)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .sts                      (sts),
    .cfg                      (cfg),
    .in_now_us                (in_now_us),
    .in_wingbeat_seen         (in_wingbeat_seen),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_led_level            (out_led_level),
    .out_left_trigger_level   (out_left_trigger_level),
    .out_right_trigger_level  (out_right_trigger_level),
    .out_left_trigger_driven  (out_left_trigger_driven),
    .out_right_trigger_driven (out_right_trigger_driven),
    .out_flying               (out_flying)
  );

endmodule

>>> tb/sv/wingbeat_synced_strobe_trigger_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wingbeat_synced_strobe_trigger_tb
// Self-checking bench for the wingbeat synced strobe trigger. Polling samples
// (time, wingbeat flag) are queued by a stimulus process and fed by a clocked
// driver with random gaps; a clocked monitor applies random stalls and checks
// every result field against an in-bench prediction of the strobe, camera and
// flying logic. Register settings change between phases, covering extremes.
// ----------------------------------------------------------------------------
module wingbeat_synced_strobe_trigger_tb;

  localparam int RING_DEPTH = 16;
  localparam longint unsigned PERCENT_FULL_SCALE = 100;
  localparam int DRAIN_CYCLES = 50;
  localparam int NUM_PHASES = 12;

  typedef struct packed {
    logic led_level;
    logic left_trigger_level;
    logic right_trigger_level;
    logic left_trigger_driven;
    logic right_trigger_driven;
    logic flying;
  } strobe_result_t;

  typedef struct packed {
    logic [wsst_pkg::TIME_W-1:0] now_us;
    logic                        beat;
  } poll_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [wsst_pkg::TIME_W-1:0] in_now_us = '0;
  logic in_wingbeat_seen = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_led_level;
  logic out_left_trigger_level;
  logic out_right_trigger_level;
  logic out_left_trigger_driven;
  logic out_right_trigger_driven;
  logic out_flying;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wsst_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [wsst_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  wingbeat_synced_strobe_trigger uut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_now_us                (in_now_us),
    .in_wingbeat_seen         (in_wingbeat_seen),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_led_level            (out_led_level),
    .out_left_trigger_level   (out_left_trigger_level),
    .out_right_trigger_level  (out_right_trigger_level),
    .out_left_trigger_driven  (out_left_trigger_driven),
    .out_right_trigger_driven (out_right_trigger_driven),
    .out_flying               (out_flying),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // predicted register and timing state
  wsst_pkg::cfg_t model_cfg;
  logic [wsst_pkg::TIME_W-1:0] last_beat_us = '0;
  logic [wsst_pkg::TIME_W-1:0] last_pulse_us = '0;
  logic pulse_done = 1'b0;
  logic flying_now = 1'b0;
  logic [wsst_pkg::COUNT_W-1:0] frame_pulses = '0;
  logic [wsst_pkg::PERIOD_W-1:0] ring_periods [RING_DEPTH];
  logic [3:0] ring_pos = '0;
  logic [4:0] ring_fill = '0;
  logic [27:0] period_sum = '0;
  logic led_on = 1'b0;
  logic camera_on = 1'b0;

  strobe_result_t expected_strobes[$];
  poll_sample_t pending_samples[$];

  int queued_samples = 0;
  int accepted_samples = 0;
  int checked_results = 0;
  int mismatches = 0;
  int pulses_fired = 0;
  int frames_started = 0;
  int settings_applied = 0;
  bit idle_on = 1'b1;

  // stimulus bookkeeping
  logic [wsst_pkg::TIME_W-1:0] clock_us = '0;
  logic [wsst_pkg::TIME_W-1:0] beat_mark = '0;

  // gap or stall length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic string strobe_field_name(int bit_index);
    case (bit_index)
      5: return "led_level";
      4: return "left_trigger_level";
      3: return "right_trigger_level";
      2: return "left_trigger_driven";
      1: return "right_trigger_driven";
      default: return "flying";
    endcase
  endfunction

  // one polling sample through the strobe logic, result queued
  function automatic void predict_strobe(logic [wsst_pkg::TIME_W-1:0] now, logic beat);
    logic [wsst_pkg::TIME_W-1:0] gap;
    logic [wsst_pkg::TIME_W-1:0] elapsed;
    longint unsigned average;
    longint unsigned threshold;
    strobe_result_t r;
    gap = now - last_beat_us;

    // beat: restart the cycle, short periods enter the average
    if (beat) begin
      last_beat_us = now;
      pulse_done = 1'b0;
      if (gap < {8'd0, model_cfg.average_accept_limit}) begin
        if (ring_fill == 5'(RING_DEPTH)) period_sum = period_sum - ring_periods[ring_pos];
        else ring_fill = ring_fill + 5'd1;
        ring_periods[ring_pos] = gap[wsst_pkg::PERIOD_W-1:0];
        period_sum = period_sum + {4'd0, gap[wsst_pkg::PERIOD_W-1:0]};
        ring_pos = ring_pos + 4'd1;
      end
      if (!flying_now) begin
        led_on = 1'b0;
        camera_on = 1'b0;
      end
      flying_now = 1'b1;
    end

    // timeout measured on the gap before this beat
    if (gap > {8'd0, model_cfg.flying_timeout}) begin
      flying_now = 1'b0;
      frame_pulses = '0;
    end

    // synthetic period while grounded
    if (!flying_now && gap >= {8'd0, model_cfg.fallback_period}) begin
      last_beat_us = now;
      pulse_done = 1'b0;
    end

    // fire or retire the pulse
    if (!pulse_done) begin
      average = (ring_fill == 0) ? 64'd0 : 64'(period_sum) / 64'(ring_fill);
      threshold = (average * 64'(model_cfg.trigger_percent)) / PERCENT_FULL_SCALE;
      elapsed = now - last_beat_us;
      if (64'(elapsed) > threshold) begin
        led_on = 1'b1;
        if (frame_pulses == 0) begin
          camera_on = 1'b1;
          frames_started++;
        end
        pulse_done = 1'b1;
        frame_pulses = frame_pulses + 8'd1;
        last_pulse_us = now;
        pulses_fired++;
      end
    end else begin
      elapsed = now - last_pulse_us;
      if (elapsed > {8'd0, model_cfg.led_pulse_width}) begin
        led_on = 1'b0;
        if (frame_pulses >= model_cfg.pulses_per_frame) begin
          camera_on = 1'b0;
          frame_pulses = '0;
        end
      end
    end

    r.led_level = led_on;
    r.left_trigger_level = model_cfg.left_camera_enable & camera_on;
    r.right_trigger_level = model_cfg.right_camera_enable & camera_on;
    r.left_trigger_driven = model_cfg.left_camera_enable;
    r.right_trigger_driven = model_cfg.right_camera_enable;
    r.flying = flying_now;
    expected_strobes.push_back(r);
  endfunction

  // sample driver
  poll_sample_t next_sample;
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        accepted_samples++;
        predict_strobe(in_now_us, in_wingbeat_seen);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          next_sample = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_now_us <= next_sample.now_us;
          in_wingbeat_seen <= next_sample.beat;
          send_gap <= idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall pattern
  strobe_result_t want_strobe;
  logic [5:0] got_bits;
  int stall_left = 0;
  int fld;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_strobes.size() == 0) begin
          $error("result with no sample pending");
          mismatches++;
        end else begin
          want_strobe = expected_strobes.pop_front();
          got_bits = {out_led_level, out_left_trigger_level, out_right_trigger_level,
                      out_left_trigger_driven, out_right_trigger_driven, out_flying};
          checked_results++;
          for (fld = 5; fld >= 0; fld--) begin
            if (got_bits[fld] !== want_strobe[fld]) begin
              $error("%s: expected %0b, actual %0b", strobe_field_name(fld),
                     want_strobe[fld], got_bits[fld]);
              mismatches++;
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idle_on) stall_left <= pick_gap();
      end
    end
  end

  // register write, predicted copy follows
  task automatic write_register(logic [wsst_pkg::CFG_INDEX_W-1:0] index,
                                logic [wsst_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      wsst_pkg::REG_TRIGGER_PERCENT:
        model_cfg.trigger_percent =
          (value[wsst_pkg::PERCENT_W-1:0] > wsst_pkg::PERCENT_MAX) ?
          wsst_pkg::PERCENT_MAX : value[wsst_pkg::PERCENT_W-1:0];
      wsst_pkg::REG_ACCEPT_LIMIT:     model_cfg.average_accept_limit = value;
      wsst_pkg::REG_FLYING_TIMEOUT:   model_cfg.flying_timeout = value;
      wsst_pkg::REG_FALLBACK_PERIOD:  model_cfg.fallback_period = value;
      wsst_pkg::REG_LED_PULSE_WIDTH:  model_cfg.led_pulse_width = value;
      wsst_pkg::REG_PULSES_PER_FRAME:
        model_cfg.pulses_per_frame = value[wsst_pkg::COUNT_W-1:0];
      wsst_pkg::REG_LEFT_ENABLE:      model_cfg.left_camera_enable = value[0];
      wsst_pkg::REG_RIGHT_ENABLE:     model_cfg.right_camera_enable = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [23:0] pct, logic [23:0] accept, logic [23:0] timeout,
                                logic [23:0] fallback, logic [23:0] width, logic [23:0] ppf,
                                logic [23:0] left, logic [23:0] right);
    write_register(wsst_pkg::REG_TRIGGER_PERCENT, pct);
    write_register(wsst_pkg::REG_ACCEPT_LIMIT, accept);
    write_register(wsst_pkg::REG_FLYING_TIMEOUT, timeout);
    write_register(wsst_pkg::REG_FALLBACK_PERIOD, fallback);
    write_register(wsst_pkg::REG_LED_PULSE_WIDTH, width);
    write_register(wsst_pkg::REG_PULSES_PER_FRAME, ppf);
    write_register(wsst_pkg::REG_LEFT_ENABLE, left);
    write_register(wsst_pkg::REG_RIGHT_ENABLE, right);
    settings_applied++;
  endtask

  // sender holds off until every result is back and the block is quiet
  task automatic wait_drained();
    while (accepted_samples != queued_samples || expected_strobes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_sample(logic [wsst_pkg::TIME_W-1:0] t, logic beat);
    poll_sample_t s;
    s.now_us = t;
    s.beat = beat;
    pending_samples.push_back(s);
    queued_samples++;
    clock_us = t;
  endtask

  // steady flight: beats near a fixed period, sampled at random steps
  task automatic fly(int n, int period, int step_lo, int step_hi);
    int k;
    int period_j;
    logic hit;
    period_j = period;
    for (k = 0; k < n; k++) begin
      clock_us = clock_us + wsst_pkg::TIME_W'($urandom_range(step_lo, step_hi));
      hit = (clock_us - beat_mark) >= wsst_pkg::TIME_W'(period_j);
      if (hit) begin
        beat_mark = clock_us;
        period_j = period - period / 16 + $urandom_range(0, period / 8);
      end
      add_sample(clock_us, hit);
    end
  endtask

  // no beats for a while: pulse width, fallback and timeout play out
  task automatic quiet(int n);
    int k;
    for (k = 0; k < n; k++)
      add_sample(clock_us + wsst_pkg::TIME_W'($urandom_range(1, 1500)), 1'b0);
  endtask

  // broken flight: a gap past the timeout, then a few ragged samples
  task automatic long_gap_beats();
    int k;
    add_sample(clock_us + {8'd0, model_cfg.flying_timeout} +
               wsst_pkg::TIME_W'($urandom_range(1, 50000)), 1'b1);
    beat_mark = clock_us;
    for (k = 0; k < 3; k++)
      add_sample(clock_us + wsst_pkg::TIME_W'($urandom_range(0, 3000)),
                 1'($urandom_range(0, 1)));
  endtask

  // noise: arbitrary times and flags
  task automatic noise_samples();
    int k;
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(0, 1)) add_sample($urandom(), 1'($urandom_range(0, 1)));
      else add_sample(clock_us + wsst_pkg::TIME_W'($urandom_range(0, 100000)),
                      1'($urandom_range(0, 1)));
    end
    beat_mark = clock_us;
  endtask

  task automatic fill_phase(int target, bit flight_only);
    int start;
    int pick;
    int period;
    start = queued_samples;
    while (queued_samples - start < target) begin
      pick = $urandom_range(0, 99);
      if (flight_only) begin
        fly(40, 40, 20, 21);
      end else if (pick < 65) begin
        period = $urandom_range(300, 12000);
        fly($urandom_range(10, 40), period, 1, period / $urandom_range(3, 12) + 1);
      end else if (pick < 80) begin
        quiet($urandom_range(3, 12));
      end else if (pick < 90) begin
        long_gap_beats();
      end else begin
        noise_samples();
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    int ph;
    model_cfg.trigger_percent = wsst_pkg::RST_TRIGGER_PERCENT;
    model_cfg.average_accept_limit = wsst_pkg::RST_ACCEPT_LIMIT;
    model_cfg.flying_timeout = wsst_pkg::RST_FLYING_TIMEOUT;
    model_cfg.fallback_period = wsst_pkg::RST_FALLBACK_PERIOD;
    model_cfg.led_pulse_width = wsst_pkg::RST_LED_PULSE_WIDTH;
    model_cfg.pulses_per_frame = wsst_pkg::RST_PULSES_PER_FRAME;
    model_cfg.left_camera_enable = 1'b1;
    model_cfg.right_camera_enable = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty average, grounded beats, timeouts, time wrap
    add_sample(32'h0000_0000, 1'b0);
    add_sample(32'h0000_0001, 1'b0);
    add_sample(32'h0000_0190, 1'b1);
    add_sample(32'h0000_0D48, 1'b1);
    add_sample(32'h0000_0DAC, 1'b0);
    add_sample(32'h0000_0FA0, 1'b0);
    add_sample(32'h0000_11F8, 1'b0);
    add_sample(32'h0000_1900, 1'b1);
    add_sample(32'h0000_1964, 1'b0);
    add_sample(32'h0000_1C20, 1'b0);
    add_sample(32'h0010_0000, 1'b0);
    add_sample(32'h0010_0001, 1'b1);
    add_sample(32'h0010_0100, 1'b1);
    add_sample(32'h0010_1000, 1'b0);
    add_sample(32'h0020_0000, 1'b1);
    add_sample(32'hFFFF_FF00, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b1);
    add_sample(32'h0000_0100, 1'b1);
    add_sample(32'h0000_0400, 1'b0);
    add_sample(32'h7FFF_FFFF, 1'b1);
    add_sample(32'h8000_0000, 1'b0);
    beat_mark = clock_us;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      idle_on = (ph % 4) != 2;
      case (ph)
        0: apply_settings(24'd50, 24'd10000, 24'd100000, 24'd5000, 24'd500, 24'd4,
                          24'd1, 24'd1);
        // saturated percent, everything averaged, no timeout, zero width
        1: apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'd1,
                          24'd0, 24'd1);
        // led never turns off, so the frame pulse count wraps
        2: apply_settings(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                          24'hFFFFFF, 24'd1, 24'd1);
        // zero pulses per frame, zero timeout, nothing averaged
        3: apply_settings(24'h000080, 24'd0, 24'd0, 24'hFFFFFF, 24'd1, 24'hFFFF00,
                          24'hFFFFFF, 24'hFFFFFE);
        default:
          apply_settings(24'($urandom_range(0, 127)), 24'($urandom_range(500, 20000)),
                         24'($urandom_range(2000, 150000)), 24'($urandom_range(0, 12000)),
                         24'($urandom_range(0, 4000)),
                         ($urandom_range(0, 7) == 0) ? 24'd255 : 24'($urandom_range(0, 10)),
                         24'($urandom_range(0, 1)), 24'($urandom_range(0, 1)));
      endcase
      case (ph)
        0, 1: fill_phase(100, 1'b0);
        2: fill_phase(600, 1'b1);
        3: fill_phase(60, 1'b0);
        default: fill_phase(60, 1'b0);
      endcase
    end
    wait_drained();

    $display("covered %0d polling samples under %0d register settings, %0d results checked",
             accepted_samples, settings_applied, checked_results);
    $display("%0d led pulses predicted, %0d of them opening a camera frame",
             pulses_fired, frames_started);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
